>>> src/spxl_pkg.sv
// Shared types and constants for the superpixel label smoothing and outline block.
package spxl_pkg;

    // Input transaction payload
    typedef struct packed {
        logic        kind;
        logic [15:0] label;
        logic [7:0]  lightness;
        logic [7:0]  chroma_a;
        logic [7:0]  chroma_b;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [7:0] out_lightness;
        logic [7:0] out_chroma_a;
        logic [7:0] out_chroma_b;
        logic       is_boundary;
        logic       last;
    } out_item_t;

    // Per-advance control carried down the pipeline
    typedef struct packed {
        logic int_p;      // smoothing target is interior
        logic int_q;      // trigger target is interior
        logic emit;       // this advance delivers a result
        logic last;       // result is the frame's final pixel
        logic n_col_ge1;  // emitted pixel has a left neighbor in the frame
        logic n_row_ge1;  // emitted pixel has an upper neighbor in the frame
    } stage_ctl_t;

    // Input kinds
    localparam logic KIND_PIXEL = 1'b0;

    // Configuration port
    localparam int          CFG_ADDR_BITS   = 2;
    localparam int          CFG_DATA_BITS   = 12;
    localparam logic [1:0]  CFG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0]  CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0]  CFG_VOTE_THRESH = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;
    localparam logic [3:0]  THRESH_RESET = 4'd6;

    // Row counter covers the frame plus the drain tail
    localparam int ROW_BITS = 13;

    // 3x3 window
    localparam int VOTE_TAPS  = 9;
    localparam int COUNT_BITS = 4;

    // Boundary paint color
    localparam logic [7:0] PAINT_L = 8'd0;
    localparam logic [7:0] PAINT_A = 8'd128;
    localparam logic [7:0] PAINT_B = 8'd128;

endpackage

>>> src/superpixel_label_smooth_and_outline.sv
// Top level: streaming 3x3 label smoothing with boundary overlay.
//
//  channel | ports                        | payload
//  --------+------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data     | kind, label, Lab color
//  result  | m_valid, m_ready, m_data     | Lab color, is_boundary, last
//  config  | cfg_we, cfg_addr, cfg_wdata  | width, height, vote threshold
//
// One transaction per cycle sustained while s_ready stays high; a result passes the
// read, vote and trigger stages after its advance, then a 4-entry queue.
// The left-neighbor smoothing loop closes inside the vote stage.
// With a three-row frame, the first drain after the last pixel waits while the
// pipeline steps itself. s_ready drops when the queue
// plus in-flight results could overflow. Reset is synchronous, no clearing pass.
module superpixel_label_smooth_and_outline #(
    parameter int MAX_WIDTH  = 1024,
    parameter int LABEL_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  spxl_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output spxl_pkg::out_item_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [spxl_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [spxl_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import spxl_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int RING   = 4 * MAX_WIDTH;
    localparam int RING_W = $clog2(RING);
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W   = $clog2(FIFO_DEPTH);
    localparam int FC_W   = $clog2(FIFO_DEPTH + 1);

    // Configuration
    logic [10:0] fw_reg;
    logic [11:0] fh_reg;
    logic [3:0]  thr_reg;
    logic [WID_W-1:0]    w_eff;
    logic [11:0]         h_eff;
    logic [ROW_BITS-1:0] h13;
    logic                cfg_hit;

    // Position counters
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [RING_W-1:0]   wp_reg, wp_next;

    // Stage 0 decode
    logic             complete, col_ge2, early, auto_adv, acc, is_pix, adv, row_wrap;
    logic             space_ok;
    logic [COL_W-1:0] col_p;
    logic [RING_W-1:0] k_dist, rd_slot;
    logic [RING_W:0]   rd_wrap;
    stage_ctl_t       ctl0;
    logic [LABEL_BITS-1:0] label_in;

    // Memories
    logic [LABEL_BITS-1:0] lb1_mem [MAX_WIDTH];
    logic [LABEL_BITS-1:0] lb2_mem [MAX_WIDTH];
    logic [23:0]           colour_mem [RING];
    logic [1:0]            tmem [MAX_WIDTH];
    logic [LABEL_BITS-1:0] lb1_rd_reg, lb2_rd_reg;
    logic [23:0]           colour_rd_reg;
    logic [1:0]            t_rd_reg;

    // Stage 1
    logic                  s1_v_reg;
    stage_ctl_t            s1_ctl_reg;
    logic [LABEL_BITS-1:0] s1_label_reg;
    logic [COL_W-1:0]      s1_colp_reg;
    logic [LABEL_BITS-1:0] top_l_reg, top_c_reg, mid_l_reg, mid_c_reg, bot_l_reg, bot_c_reg;
    logic [LABEL_BITS-1:0] taps [VOTE_TAPS];
    logic [LABEL_BITS-1:0] win_label, smoothed;
    logic [COUNT_BITS-1:0] win_count;

    // Stage 2
    logic                  s2_v_reg;
    stage_ctl_t            s2_ctl_reg;
    logic [LABEL_BITS-1:0] s2_lq_reg, s2_lr_reg, s2_lp_reg;
    logic [23:0]           s2_colour_reg;
    logic [COL_W-1:0]      s2_colp_reg;
    logic                  t_new, ta, tb, is_b;
    logic                  tq_prev_reg, u1_reg, u2_reg, tb_prev_reg;
    out_item_t             res;

    // Result queue
    out_item_t          fifo_mem [FIFO_DEPTH];
    logic [FP_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FC_W-1:0]    cnt_reg, cnt_next;
    logic               push, pop;
    logic [FC_W:0]      load;

    // Effective frame size
    always_comb begin
        if (fw_reg < 11'd3) begin
            w_eff = WID_W'(3);
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(fw_reg);
        end
        h_eff = (fh_reg < 12'd3) ? 12'd3 : fh_reg;
        h13   = {1'b0, h_eff};
    end

    assign cfg_hit = cfg_we && (cfg_addr == CFG_FRAME_WIDTH || cfg_addr == CFG_FRAME_HEIGHT ||
                                cfg_addr == CFG_VOTE_THRESH);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= WIDTH_RESET;
            fh_reg  <= HEIGHT_RESET;
            thr_reg <= THRESH_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  fw_reg  <= cfg_wdata[10:0];
                CFG_FRAME_HEIGHT: fh_reg  <= cfg_wdata[11:0];
                CFG_VOTE_THRESH:  thr_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Stage 0: position decode of the advance index
    always_comb begin
        complete = row_reg >= h13;
        col_ge2  = col_reg >= COL_W'(2);
        early    = (row_reg < ROW_BITS'(3)) || (row_reg == ROW_BITS'(3) && !col_ge2);
        auto_adv = complete && early;
        row_wrap = (WID_W'(col_reg) + WID_W'(1)) == w_eff;
        col_p    = (col_reg == '0) ? COL_W'(w_eff - WID_W'(1)) : col_reg - COL_W'(1);

        ctl0.int_p = col_ge2 && row_reg >= ROW_BITS'(2) && row_reg <= h13 - ROW_BITS'(1);
        ctl0.int_q = col_ge2 && row_reg >= ROW_BITS'(3) && row_reg <= h13;
        if (col_ge2) begin
            ctl0.emit      = row_reg >= ROW_BITS'(3) && row_reg <= h13 + ROW_BITS'(2);
            ctl0.n_row_ge1 = row_reg >= ROW_BITS'(4);
        end else begin
            ctl0.emit      = row_reg >= ROW_BITS'(4) && row_reg <= h13 + ROW_BITS'(3);
            ctl0.n_row_ge1 = row_reg >= ROW_BITS'(5);
        end
        ctl0.last      = col_reg == COL_W'(1) && row_reg == h13 + ROW_BITS'(3);
        ctl0.n_col_ge1 = !col_ge2 || col_reg >= COL_W'(3);

        // Color ring slot of the pixel being emitted
        k_dist  = RING_W'({w_eff, 1'b0}) + RING_W'(w_eff) + RING_W'(2);
        rd_wrap = {1'b0, wp_reg} + (RING_W + 1)'(RING) - {1'b0, k_dist};
        rd_slot = (wp_reg >= k_dist) ? wp_reg - k_dist : RING_W'(rd_wrap);
    end

    // Input handshake and advance decision
    always_comb begin
        load     = (FC_W + 1)'(cnt_reg) + (FC_W + 1)'(s1_v_reg && s1_ctl_reg.emit) +
                   (FC_W + 1)'(s2_v_reg && s2_ctl_reg.emit);
        space_ok = load < (FC_W + 1)'(FIFO_DEPTH);
        s_ready  = !auto_adv && space_ok;
        acc      = s_valid && s_ready;
        is_pix   = acc && !complete && s_data.kind == KIND_PIXEL;
        adv      = auto_adv || (acc && complete) || is_pix;
        label_in = LABEL_BITS'(s_data.label);
    end

    // Counter next values
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        wp_next  = wp_reg;
        if (cfg_hit || (adv && ctl0.emit && ctl0.last)) begin
            col_next = '0;
            row_next = '0;
            wp_next  = '0;
        end else if (adv) begin
            if (row_wrap) begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
            wp_next = (wp_reg == RING_W'(RING - 1)) ? '0 : wp_reg + RING_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            wp_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            wp_reg  <= wp_next;
        end
    end

    // Raw line, color ring: read at stage 0, write on pixel advance
    always_ff @(posedge aclk) begin
        lb1_rd_reg    <= lb1_mem[col_reg];
        colour_rd_reg <= colour_mem[rd_slot];
        if (is_pix) begin
            lb1_mem[col_reg]   <= label_in;
            colour_mem[wp_reg] <= {s_data.chroma_b, s_data.chroma_a, s_data.lightness};
        end
    end

    // Smoothed line: read at stage 0, written back by stage 1
    always_ff @(posedge aclk) begin
        lb2_rd_reg <= lb2_mem[col_reg];
        if (s1_v_reg) begin
            lb2_mem[s1_colp_reg] <= smoothed;
        end
    end

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctl_reg   <= ctl0;
            s1_label_reg <= label_in;
            s1_colp_reg  <= col_p;
        end
    end

    // Stage 1: window vote
    always_comb begin
        taps[0] = top_l_reg;
        taps[1] = top_c_reg;
        taps[2] = lb2_rd_reg;
        taps[3] = mid_l_reg;
        taps[4] = mid_c_reg;
        taps[5] = lb1_rd_reg;
        taps[6] = bot_l_reg;
        taps[7] = bot_c_reg;
        taps[8] = s1_label_reg;
    end

    spxl_vote #(
        .LABEL_BITS (LABEL_BITS)
    ) u_vote (
        .taps      (taps),
        .win_label (win_label),
        .win_count (win_count)
    );

    assign smoothed = (s1_ctl_reg.int_p && win_count >= thr_reg) ? win_label : mid_c_reg;

    // Window shift; the smoothed center becomes the next left neighbor
    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            top_l_reg <= top_c_reg;
            top_c_reg <= lb2_rd_reg;
            mid_l_reg <= smoothed;
            mid_c_reg <= lb1_rd_reg;
            bot_l_reg <= bot_c_reg;
            bot_c_reg <= s1_label_reg;
        end
    end

    // Trigger line memory: {t one row up, t two rows up} per column
    always_ff @(posedge aclk) begin
        t_rd_reg <= tmem[s1_colp_reg];
        if (s2_v_reg) begin
            tmem[s2_colp_reg] <= {t_new, ta};
        end
    end

    // Stage 2 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            s2_ctl_reg    <= s1_ctl_reg;
            s2_lq_reg     <= top_c_reg;
            s2_lr_reg     <= lb2_rd_reg;
            s2_lp_reg     <= smoothed;
            s2_colour_reg <= colour_rd_reg;
            s2_colp_reg   <= s1_colp_reg;
        end
    end

    // Stage 2: trigger and paint of the emitted pixel
    always_comb begin
        ta    = t_rd_reg[1];
        tb    = t_rd_reg[0];
        t_new = s2_ctl_reg.int_q && (s2_lq_reg != s2_lp_reg || s2_lq_reg != s2_lr_reg);
        is_b  = (s2_ctl_reg.n_row_ge1 && tb_prev_reg) || (s2_ctl_reg.n_col_ge1 && u2_reg) ||
                u1_reg || ta || tq_prev_reg;
        if (is_b) begin
            res.out_lightness = PAINT_L;
            res.out_chroma_a  = PAINT_A;
            res.out_chroma_b  = PAINT_B;
        end else begin
            res.out_lightness = s2_colour_reg[7:0];
            res.out_chroma_a  = s2_colour_reg[15:8];
            res.out_chroma_b  = s2_colour_reg[23:16];
        end
        res.is_boundary = is_b;
        res.last        = s2_ctl_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (s2_v_reg) begin
            tq_prev_reg <= t_new;
            u1_reg      <= ta;
            u2_reg      <= u1_reg;
            tb_prev_reg <= tb;
        end
    end

    // Result queue
    assign push    = s2_v_reg && s2_ctl_reg.emit;
    assign pop     = m_valid && m_ready;
    assign m_valid = cnt_reg != '0;
    assign m_data  = fifo_mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + FC_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - FC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FP_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

endmodule

>>> src/spxl_vote.sv
// Majority vote over a 3x3 label window, earliest tap wins ties.
module spxl_vote #(
    parameter int LABEL_BITS = 16
) (
    input  logic [LABEL_BITS-1:0]       taps [spxl_pkg::VOTE_TAPS],
    output logic [LABEL_BITS-1:0]       win_label,
    output logic [spxl_pkg::COUNT_BITS-1:0] win_count
);
    import spxl_pkg::*;

    logic [COUNT_BITS-1:0] cnt [VOTE_TAPS];

    // Matches per tap
    always_comb begin
        for (int i = 0; i < VOTE_TAPS; i++) begin
            cnt[i] = '0;
            for (int j = 0; j < VOTE_TAPS; j++) begin
                if (taps[i] == taps[j]) begin
                    cnt[i] = cnt[i] + COUNT_BITS'(1);
                end
            end
        end
    end

    // Strictly higher count replaces, so the first tap holds ties
    always_comb begin
        win_label = taps[0];
        win_count = cnt[0];
        for (int i = 1; i < VOTE_TAPS; i++) begin
            if (cnt[i] > win_count) begin
                win_label = taps[i];
                win_count = cnt[i];
            end
        end
    end

endmodule
